// ===== src/rled_pkg.sv =====
`timescale 1ns / 1ps

package rled_pkg;

  localparam int SIZE_WIDTH_DEF = 24;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int MAX_RESULTS = 3;
  localparam int COUNT_WIDTH = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_WIDTH = $clog2(MAX_RESULTS);

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_SIZE = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEST_ADDRESS = 8'd1;

  localparam int FLAG_RUN_BIT = 7;
  localparam logic [7:0] RUN_BIAS = 8'd3;
  localparam logic [7:0] LIT_BIAS = 8'd1;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_RUN  = 2'd1,
    PH_LIT  = 2'd2
  } rled_phase_t;

  typedef struct packed {
    logic [15:0] halfword;
    logic [31:0] write_address;
    logic [6:0]  repeat_count;
    logic        last;
  } rled_result_t;

  typedef struct packed {
    rled_result_t [MAX_RESULTS-1:0] res;
    logic [COUNT_WIDTH-1:0]         count;
  } rled_bundle_t;

endpackage

// ===== src/rled_if.sv =====
`timescale 1ns / 1ps

interface rled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

interface rled_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] halfword;
  logic [31:0] write_address;
  logic [6:0]  repeat_count;
  logic        last;
  modport source (output valid, output halfword, output write_address,
                  output repeat_count, output last, input ready);
  modport sink (input valid, input halfword, input write_address,
                input repeat_count, input last, output ready);
endinterface

interface rled_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/rle_decoder_halfword_writer.sv =====
// an accepted byte passes the input register and the output buffer before its first result reaches dst
// throughput: one byte per cycle while dst is ready and each byte gives at most one result;
//   a byte that gives k results (k up to 3, a run) holds the input until dst has taken all k
// reset: rst (synchronous) clears both config registers to zero, returns
//   the decoder to the start of a stream and empties both buffers
`timescale 1ns / 1ps

module rle_decoder_halfword_writer #(
  parameter int SIZE_WIDTH = rled_pkg::SIZE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rled_in_if.sink     src,
  rled_out_if.source  dst,
  rled_cfg_if.sink    cfg
);
  import rled_pkg::*;

  logic [SIZE_WIDTH-1:0] out_size;
  logic [31:0]           dest_address;
  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  can_load;
  logic                  advance;
  rled_bundle_t          bundle;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_size <= '0;
      dest_address <= '0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_OUT_SIZE) begin
        out_size <= cfg.data[SIZE_WIDTH-1:0];
      end else if (cfg.index == REG_DEST_ADDRESS) begin
        dest_address <= cfg.data;
      end
    end
  end

  // input register: holds one byte while results wait downstream
  assign advance = in_valid && can_load;
  assign src.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (src.ready) begin
      in_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      in_byte <= src.src_byte;
    end
  end

  rled_core #(.SIZE_WIDTH(SIZE_WIDTH)) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .src_byte     (in_byte),
    .out_size     (out_size),
    .dest_address (dest_address),
    .bundle       (bundle)
  );

  rled_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .bundle   (bundle),
    .can_load (can_load),
    .dst      (dst)
  );

endmodule

// ===== src/rled_core.sv =====
`timescale 1ns / 1ps

module rled_core #(
  parameter int SIZE_WIDTH = rled_pkg::SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            src_byte,
  input  logic [SIZE_WIDTH-1:0] out_size,
  input  logic [31:0]           dest_address,
  output rled_pkg::rled_bundle_t bundle
);
  import rled_pkg::*;

  rled_phase_t           phase, phase_next;
  logic [7:0]            literal_left, literal_left_next;
  logic [SIZE_WIDTH-1:0] bytes_written, bytes_written_next;
  logic [7:0]            pending_byte, pending_byte_next;
  logic                  pending_valid, pending_valid_next;

  function automatic logic [31:0] addr_at(input logic [31:0] base,
                                          input logic [SIZE_WIDTH-1:0] cnt);
    logic [SIZE_WIDTH-1:0] even;
    even = {cnt[SIZE_WIDTH-1:1], 1'b0};
    return base + 32'(even);
  endfunction

  always_comb begin
    logic [SIZE_WIDTH-1:0]  remaining;
    logic [7:0]             len;
    logic [6:0]             pairs;
    logic [COUNT_WIDTH-1:0] n;
    logic                   end_chk;

    phase_next = phase;
    literal_left_next = literal_left;
    bytes_written_next = bytes_written;
    pending_byte_next = pending_byte;
    pending_valid_next = pending_valid;
    bundle = '0;
    n = '0;
    end_chk = 1'b0;
    remaining = '0;
    len = '0;
    pairs = '0;

    if (step && out_size != '0) begin
      if (bytes_written >= out_size) begin
        // size was lowered under the stream: flush and start over
        if (pending_valid) begin
          bundle.res[0] = '{halfword: {8'h00, pending_byte},
                            write_address: addr_at(dest_address, bytes_written),
                            repeat_count: 7'd1, last: 1'b1};
          n = COUNT_WIDTH'(1);
        end
        phase_next = PH_FLAG;
        literal_left_next = '0;
        bytes_written_next = '0;
        pending_byte_next = '0;
        pending_valid_next = 1'b0;
      end else begin
        unique case (phase)
          PH_RUN: begin
            remaining = out_size - bytes_written;
            len = (remaining < SIZE_WIDTH'(literal_left)) ? remaining[7:0] : literal_left;
            // complete the waiting odd byte first
            if (pending_valid && len != 8'd0) begin
              bundle.res[SLOT_WIDTH'(n)] = '{halfword: {src_byte, pending_byte},
                  write_address: addr_at(dest_address, bytes_written_next),
                  repeat_count: 7'd1, last: 1'b0};
              n = n + COUNT_WIDTH'(1);
              bytes_written_next = bytes_written_next + SIZE_WIDTH'(1);
              pending_valid_next = 1'b0;
              pending_byte_next = '0;
              len = len - 8'd1;
            end
            pairs = len[7:1];
            if (pairs != 7'd0) begin
              bundle.res[SLOT_WIDTH'(n)] = '{halfword: {src_byte, src_byte},
                  write_address: addr_at(dest_address, bytes_written_next),
                  repeat_count: pairs, last: 1'b0};
              n = n + COUNT_WIDTH'(1);
              bytes_written_next = bytes_written_next + SIZE_WIDTH'({pairs, 1'b0});
            end
            if (len[0]) begin
              pending_byte_next = src_byte;
              pending_valid_next = 1'b1;
              bytes_written_next = bytes_written_next + SIZE_WIDTH'(1);
            end
            phase_next = PH_FLAG;
            literal_left_next = '0;
            end_chk = 1'b1;
          end
          PH_LIT: begin
            if (pending_valid) begin
              bundle.res[SLOT_WIDTH'(n)] = '{halfword: {src_byte, pending_byte},
                  write_address: addr_at(dest_address, bytes_written),
                  repeat_count: 7'd1, last: 1'b0};
              n = n + COUNT_WIDTH'(1);
              pending_valid_next = 1'b0;
              pending_byte_next = '0;
            end else begin
              pending_byte_next = src_byte;
              pending_valid_next = 1'b1;
            end
            bytes_written_next = bytes_written + SIZE_WIDTH'(1);
            if (literal_left != 8'd0) begin
              literal_left_next = literal_left - 8'd1;
            end
            if (literal_left_next == 8'd0) begin
              phase_next = PH_FLAG;
            end
            end_chk = 1'b1;
          end
          default: begin
            if (src_byte[FLAG_RUN_BIT]) begin
              literal_left_next = {1'b0, src_byte[6:0]} + RUN_BIAS;
              phase_next = PH_RUN;
            end else begin
              literal_left_next = {1'b0, src_byte[6:0]} + LIT_BIAS;
              phase_next = PH_LIT;
            end
          end
        endcase

        if (end_chk && bytes_written_next == out_size) begin
          // odd size leaves one byte with a zero upper half
          if (pending_valid_next) begin
            bundle.res[SLOT_WIDTH'(n)] = '{halfword: {8'h00, pending_byte_next},
                write_address: addr_at(dest_address, bytes_written_next),
                repeat_count: 7'd1, last: 1'b0};
            n = n + COUNT_WIDTH'(1);
          end
          if (n != '0) begin
            bundle.res[SLOT_WIDTH'(n - COUNT_WIDTH'(1))].last = 1'b1;
          end
          phase_next = PH_FLAG;
          literal_left_next = '0;
          bytes_written_next = '0;
          pending_byte_next = '0;
          pending_valid_next = 1'b0;
        end
      end
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLAG;
      literal_left <= '0;
      bytes_written <= '0;
      pending_byte <= '0;
      pending_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      literal_left <= literal_left_next;
      bytes_written <= bytes_written_next;
      pending_byte <= pending_byte_next;
      pending_valid <= pending_valid_next;
    end
  end

  // an odd byte waits exactly when an odd count has gone out
  assert property (@(posedge clk) disable iff (rst) pending_valid == bytes_written[0])
    else $error("pending byte out of step with byte count");

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FLAG) == (literal_left == 8'd0))
    else $error("length counter out of step with phase");

endmodule

// ===== src/rled_outbuf.sv =====
`timescale 1ns / 1ps

module rled_outbuf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  rled_pkg::rled_bundle_t bundle,
  output logic                   can_load,
  rled_out_if.source             dst
);
  import rled_pkg::*;

  rled_bundle_t           held;
  logic [COUNT_WIDTH-1:0] left;
  logic [SLOT_WIDTH-1:0]  slot;
  rled_result_t           cur;

  assign cur = held.res[slot];
  assign dst.valid = (left != '0);
  assign dst.halfword = cur.halfword;
  assign dst.write_address = cur.write_address;
  assign dst.repeat_count = cur.repeat_count;
  assign dst.last = cur.last;

  // take a new set when empty or when its final item leaves now
  assign can_load = (left == '0) || (left == COUNT_WIDTH'(1) && dst.ready);

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      slot <= '0;
    end else if (load) begin
      left <= bundle.count;
      slot <= '0;
    end else if (dst.valid && dst.ready) begin
      left <= left - COUNT_WIDTH'(1);
      slot <= slot + SLOT_WIDTH'(1);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    load && bundle.count != '0 |=> dst.valid)
    else $error("loaded results not presented");

  assert property (@(posedge clk) disable iff (rst)
    left != '0 |-> (32'(slot) + 32'(left)) <= MAX_RESULTS)
    else $error("result slot beyond buffer");

endmodule
